// ===== hw/rtl/checked_size_arith_unit_defines.svh =====
// Assertion macros for the checked size arithmetic unit
`ifndef CHECKED_SIZE_ARITH_UNIT_DEFINES_SVH
`define CHECKED_SIZE_ARITH_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define CSA_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("csa assertion failed");
`define CSA_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("csa assertion failed");
`else
`define CSA_ASSERT_IMP(label, ante, cons)
`define CSA_ASSERT_NXT(label, ante, cons)
`endif
`endif

// ===== hw/rtl/csa_pkg.sv =====
package csa_pkg;
  localparam int WIDTH     = 64;
  localparam int FIELD_W   = 64;
  localparam int HALF      = (WIDTH + 1) / 2;
  localparam int ALIGN_LAT = WIDTH + 2;
  localparam int MUL_LAT   = 3;
  localparam int MUL_TAP   = ALIGN_LAT - 1 - MUL_LAT;

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_MUL    = 2'd1;
  localparam logic [1:0] OP_ALIGN  = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [FIELD_W-1:0] operand_a;
    logic [FIELD_W-1:0] operand_b;
  } req_t;

  typedef struct packed {
    logic [FIELD_W-1:0] value;
    logic               ok;
  } rsp_t;

  typedef struct packed {
    logic [WIDTH-1:0] value;
    logic             ok;
  } res_t;
endpackage

// ===== hw/rtl/csa_mul.sv =====
module csa_mul (
  input  logic                      clk,
  input  logic                      en,
  input  logic [csa_pkg::WIDTH-1:0] a,
  input  logic [csa_pkg::WIDTH-1:0] b,
  output csa_pkg::res_t             res
);
  localparam int W = csa_pkg::WIDTH;
  localparam int H = csa_pkg::HALF;
  localparam int L = W - H;

  logic [2*H-1:0] ll;
  logic [H+L-1:0] lh;
  logic [H+L-1:0] hl;
  logic [2*L-1:0] hh;
  logic           zero1;
  logic [2*H-1:0] ll2;
  logic [H+L:0]   mid;
  logic           hh_nz;
  logic           zero2;
  logic [3*H+1:0] full;

  assign full = (3*H+2)'(ll2) + ((3*H+2)'(mid) << H);

  always_ff @(posedge clk) begin
    if (en) begin
      ll    <= a[H-1:0] * b[H-1:0];
      lh    <= a[H-1:0] * b[W-1:H];
      hl    <= a[W-1:H] * b[H-1:0];
      hh    <= a[W-1:H] * b[W-1:H];
      zero1 <= (a == '0) || (b == '0);
      ll2   <= ll;
      mid   <= (H+L+1)'(lh) + (H+L+1)'(hl);
      hh_nz <= (hh != '0);
      zero2 <= zero1;
      if (zero2) begin
        res.ok    <= 1'b1;
        res.value <= '0;
      end else if (!hh_nz && (full[3*H+1:W] == '0)) begin
        res.ok    <= 1'b1;
        res.value <= full[W-1:0];
      end else begin
        res.ok    <= 1'b0;
        res.value <= '0;
      end
    end
  end
endmodule

// ===== hw/rtl/csa_align.sv =====
module csa_align (
  input  logic                      clk,
  input  logic                      en,
  input  logic [csa_pkg::WIDTH-1:0] x,
  input  logic [csa_pkg::WIDTH-1:0] al,
  output csa_pkg::res_t             res
);
  localparam int W = csa_pkg::WIDTH;

  logic [W-1:0] rem [W];
  logic [W-1:0] xs  [W];
  logic [W-1:0] als [W];
  logic         pass;
  logic [W-1:0] gap;
  logic [W-1:0] xg;
  logic [W:0]   sum;

  for (genvar k = 0; k < W; k++) begin : g_step
    logic [W-1:0] prev_rem;
    logic [W-1:0] prev_x;
    logic [W-1:0] prev_al;
    logic [W:0]   t;
    if (k == 0) begin : g_first
      assign prev_rem = '0;
      assign prev_x   = x;
      assign prev_al  = al;
    end else begin : g_rest
      assign prev_rem = rem[k-1];
      assign prev_x   = xs[k-1];
      assign prev_al  = als[k-1];
    end
    assign t = {prev_rem, prev_x[W-1-k]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= (t >= {1'b0, prev_al}) ? W'(t - {1'b0, prev_al}) : t[W-1:0];
        xs[k]  <= prev_x;
        als[k] <= prev_al;
      end
    end
  end

  assign sum = {1'b0, xg} + {1'b0, gap};

  always_ff @(posedge clk) begin
    if (en) begin
      pass <= (als[W-1] == '0) || (rem[W-1] == '0);
      gap  <= als[W-1] - rem[W-1];
      xg   <= xs[W-1];
      if (pass) begin
        res.ok    <= 1'b1;
        res.value <= xg;
      end else begin
        res.ok    <= !sum[W];
        res.value <= sum[W] ? '0 : sum[W-1:0];
      end
    end
  end
endmodule

// ===== hw/rtl/checked_size_arith_unit.sv =====
// Checked add, multiply and align-up on unsigned operands of WIDTH bits.
// One transaction is accepted every cycle unless a result waits unaccepted.
// The pipeline depth is set by the remainder for align-up, a restoring
// divider with one remainder bit per stage, and every operation travels
// through the same pipeline so results keep order.
// The whole pipeline holds when a result waits unaccepted. The ok flag is
// low on overflow and for the unused operation code, and value is then zero.
`include "checked_size_arith_unit_defines.svh"
module checked_size_arith_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  csa_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output csa_pkg::rsp_t rsp
);
  localparam int W = csa_pkg::WIDTH;
  localparam int D = csa_pkg::ALIGN_LAT;

  logic         en;
  logic         vld  [D];
  logic [1:0]   op_d [D];
  logic [W-1:0] a_d  [D];
  logic [W-1:0] b_d  [D];
  logic [W:0]   add_sum;
  logic         tail_aln;
  logic         tail_mul;
  logic         tail_zero;
  csa_pkg::res_t mul_res;
  csa_pkg::res_t aln_res;
  csa_pkg::res_t fin;

  assign en        = !rsp_valid || rsp_ready;
  assign req_ready = en;
  assign add_sum   = {1'b0, a_d[D-1]} + {1'b0, b_d[D-1]};
  assign tail_aln  = vld[D-1] && (op_d[D-1] == csa_pkg::OP_ALIGN);
  assign tail_mul  = vld[D-1] && (op_d[D-1] == csa_pkg::OP_MUL);
  assign tail_zero = (a_d[D-1] == '0) || (b_d[D-1] == '0);

  csa_mul u_mul (
    .clk (clk),
    .en  (en),
    .a   (a_d[csa_pkg::MUL_TAP]),
    .b   (b_d[csa_pkg::MUL_TAP]),
    .res (mul_res)
  );

  csa_align u_align (
    .clk (clk),
    .en  (en),
    .x   (req.operand_a[W-1:0]),
    .al  (req.operand_b[W-1:0]),
    .res (aln_res)
  );

  always_comb begin
    unique case (op_d[D-1])
      csa_pkg::OP_ADD: begin
        fin.ok    = !add_sum[W];
        fin.value = add_sum[W] ? '0 : add_sum[W-1:0];
      end
      csa_pkg::OP_MUL:   fin = mul_res;
      csa_pkg::OP_ALIGN: fin = aln_res;
      default: begin
        fin.ok    = 1'b0;
        fin.value = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < D; j++) begin
        vld[j] <= 1'b0;
      end
      rsp_valid <= 1'b0;
    end else if (en) begin
      vld[0] <= req_valid;
      for (int j = 1; j < D; j++) begin
        vld[j] <= vld[j-1];
      end
      rsp_valid <= vld[D-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op_d[0] <= req.req_type;
      a_d[0]  <= req.operand_a[W-1:0];
      b_d[0]  <= req.operand_b[W-1:0];
      for (int j = 1; j < D; j++) begin
        op_d[j] <= op_d[j-1];
        a_d[j]  <= a_d[j-1];
        b_d[j]  <= b_d[j-1];
      end
      rsp.ok    <= fin.ok;
      rsp.value <= csa_pkg::FIELD_W'(fin.value);
    end
  end

  `CSA_ASSERT_IMP(a_fail_zero, rsp_valid && !rsp.ok, rsp.value == '0)
  `CSA_ASSERT_IMP(a_align_up, tail_aln && aln_res.ok, aln_res.value >= a_d[D-1])
  `CSA_ASSERT_IMP(a_mul_zero, tail_mul && tail_zero, mul_res.ok && (mul_res.value == '0))
  `CSA_ASSERT_NXT(a_enter, req_valid && req_ready, vld[0])
endmodule

// ===== tb/sv/checked_size_arith_unit_checker.sv =====
module checked_size_arith_unit_checker (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  input  logic          req_ready,
  input  csa_pkg::req_t req,
  input  logic          rsp_valid,
  input  logic          rsp_ready,
  input  csa_pkg::rsp_t rsp,
  output int            fail_count,
  output int            pending
);
  import csa_pkg::*;

  typedef logic [WIDTH-1:0] word_t;

  rsp_t expected_rsps[$];

  // The sum is formed one bit wider so the carry out is the overflow flag.
  function automatic logic sum_fits(word_t a, word_t b, output word_t s);
    logic [WIDTH:0] wide;
    wide = {1'b0, a} + {1'b0, b};
    s = wide[WIDTH-1:0];
    return !wide[WIDTH];
  endfunction

  function automatic rsp_t compute_rsp(req_t r);
    word_t a, b, s, msk, rem;
    logic [2*WIDTH-1:0] prod;
    logic fits;
    rsp_t o;
    a = r.operand_a[WIDTH-1:0];
    b = r.operand_b[WIDTH-1:0];
    s = '0;
    fits = 1'b0;
    case (r.req_type)
      OP_ADD: fits = sum_fits(a, b, s);
      OP_MUL: begin
        prod = a * b;
        fits = (prod[2*WIDTH-1:WIDTH] == '0);
        s = prod[WIDTH-1:0];
      end
      OP_ALIGN: begin
        if (b == '0) begin
          s = a;
          fits = 1'b1;
        end else begin
          msk = b - 1'b1;
          if ((b & msk) == '0) begin
            if ((a & msk) == '0) begin
              s = a;
              fits = 1'b1;
            end else begin
              fits = sum_fits(a, msk, s);
              s = s & ~msk;
            end
          end else begin
            rem = a % b;
            if (rem == '0) begin
              s = a;
              fits = 1'b1;
            end else begin
              fits = sum_fits(a, b - rem, s);
            end
          end
        end
      end
      default: fits = 1'b0;
    endcase
    o = '0;
    o.ok = fits;
    if (fits) o.value[WIDTH-1:0] = s;
    return o;
  endfunction

  task automatic report(string what, logic [FIELD_W-1:0] got, logic [FIELD_W-1:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    rsp_t want;
    if (!rst) begin
      if (req_valid && req_ready) expected_rsps.push_back(compute_rsp(req));
      if (rsp_valid && rsp_ready) begin
        if (expected_rsps.size() == 0) begin
          report("unexpected transaction", rsp.value, '0);
        end else begin
          want = expected_rsps.pop_front();
          if (rsp.value !== want.value) report("value", rsp.value, want.value);
          if (rsp.ok !== want.ok) report("ok", rsp.ok, want.ok);
        end
      end
    end
    pending = expected_rsps.size();
  end
endmodule

// ===== tb/sv/checked_size_arith_unit_tb.sv =====
module checked_size_arith_unit_tb;
  import csa_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;
  int fail_count;
  int pending;
  req_t ops[$];

  always #2 clk = ~clk;

  checked_size_arith_unit dut (.*);

  checked_size_arith_unit_checker chk (.*);

  function automatic logic [63:0] pick_word();
    logic [63:0] w;
    int p;
    w = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0: w = '0;
      1: w = '1;
      2: w = 64'd1 << $urandom_range(0, 63);
      3: w = w >> $urandom_range(32, 63);
      4: begin
        p = $urandom_range(0, 63);
        w = (64'd1 << p) - $urandom_range(0, 2);
      end
      5: w = '1 - $urandom_range(0, 100);
      default: ;
    endcase
    return w;
  endfunction

  function automatic req_t make_req(logic [1:0] op, logic [63:0] a, logic [63:0] b);
    req_t r;
    r.req_type = op;
    r.operand_a = a;
    r.operand_b = b;
    return r;
  endfunction

  initial begin
    logic [1:0] op;
    ops.push_back(make_req(OP_ADD, '0, '0));
    ops.push_back(make_req(OP_ADD, '1, 64'd1));
    ops.push_back(make_req(OP_ADD, '1, '0));
    ops.push_back(make_req(OP_ADD, 64'h8000_0000_0000_0000, 64'h7fff_ffff_ffff_ffff));
    ops.push_back(make_req(OP_MUL, '0, '1));
    ops.push_back(make_req(OP_MUL, '1, '0));
    ops.push_back(make_req(OP_MUL, '1, 64'd1));
    ops.push_back(make_req(OP_MUL, 64'h1_0000_0000, 64'h1_0000_0000));
    ops.push_back(make_req(OP_MUL, 64'hffff_ffff, 64'h1_0000_0001));
    ops.push_back(make_req(OP_MUL, '1, '1));
    ops.push_back(make_req(OP_ALIGN, 64'd1234, '0));
    ops.push_back(make_req(OP_ALIGN, 64'd4096, 64'd4096));
    ops.push_back(make_req(OP_ALIGN, 64'd4097, 64'd4096));
    ops.push_back(make_req(OP_ALIGN, '1, 64'd8));
    ops.push_back(make_req(OP_ALIGN, '1, 64'h8000_0000_0000_0000));
    ops.push_back(make_req(OP_ALIGN, 64'd100, 64'd7));
    ops.push_back(make_req(OP_ALIGN, 64'd98, 64'd7));
    ops.push_back(make_req(OP_ALIGN, '1 - 64'd1, 64'd3));
    ops.push_back(make_req(OP_ALIGN, '1, '1));
    ops.push_back(make_req(OP_ALIGN, 64'd5, '1));
    ops.push_back(make_req(OP_ALIGN, '0, 64'd12));
    ops.push_back(make_req(OP_UNUSED, '1, '1));
    ops.push_back(make_req(OP_UNUSED, '0, '0));
    repeat (600) begin
      op = $urandom_range(0, 15) == 0 ? OP_UNUSED : 2'($urandom_range(0, 2));
      ops.push_back(make_req(op, pick_word(), pick_word()));
    end
  end

  initial begin
    int gap;
    int burst;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    while (ops.size() > 0) begin
      burst = $urandom_range(1, 30);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      while (burst > 0 && ops.size() > 0) begin
        req_valid <= 1'b1;
        req <= ops.pop_front();
        @(posedge clk);
        while (!req_ready) @(posedge clk);
        burst--;
      end
    end
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (WIDTH + 20) @(posedge clk);
    if (fail_count == 0) begin
      $display("checked_size_arith_unit_tb OK");
    end else begin
      $display("checked_size_arith_unit_tb NOT OK");
    end
    $finish;
  end

  initial begin
    int count;
    int pattern;
    @(negedge rst);
    repeat (40) @(posedge clk);
    rsp_ready <= 1'b0;
    for (count = 0; count < 300; count++) @(posedge clk);
    forever begin
      pattern = $urandom_range(0, 3);
      repeat ($urandom_range(1, 40)) begin
        @(posedge clk);
        case (pattern)
          0: rsp_ready <= 1'b1;
          1: rsp_ready <= $urandom_range(0, 1);
          2: rsp_ready <= ($urandom_range(0, 4) != 0);
          default: rsp_ready <= ~rsp_ready;
        endcase
      end
    end
  end

  initial begin
    #2000000;
    $display("checked_size_arith_unit_tb NOT OK");
    $finish;
  end
endmodule
